FILE: hdl/ipdc_pkg.sv
package ipdc_pkg;

   // command codes carried in req_tuser
   localparam logic CMD_WRITE   = 1'b0;
   localparam logic CMD_PREDICT = 1'b1;

   // prediction modes
   localparam logic MODE_PLANAR = 1'b0;
   localparam logic MODE_DC     = 1'b1;

   // block size limits, as log2 of n
   localparam int LG_MIN = 2;
   localparam int LG_MAX = 5;

   localparam int LG_W   = 3;
   localparam int POS_W  = 5;
   localparam int PIX_W  = 8;
   localparam int IDX_W  = 8;
   // n up to 32, sweep count up to n+1, weights up to n
   localparam int CNT_W  = 6;
   // 2n samples of 8 bits plus rounding, n up to 32
   localparam int SUM_W  = 14;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_REISSUE,
      ST_CALC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              mode;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [LG_W-1:0]   lg;
      logic [PIX_W-1:0]  left_y;
      logic [PIX_W-1:0]  top_x;
      logic [PIX_W-1:0]  bottom_left;
      logic [PIX_W-1:0]  top_right;
      logic [PIX_W-1:0]  dc;
   } calc_in_type;

endpackage

FILE: hdl/ipdc_pixel_calc.sv
module ipdc_pixel_calc (
   input  ipdc_pkg::calc_in_type         calc_in,
   output logic [ipdc_pkg::PIX_W-1:0]    pix
);

   localparam int EdgeW = 10;

   logic [ipdc_pkg::CNT_W-1:0] n;
   logic [ipdc_pkg::CNT_W-1:0] w_left, w_right, w_top, w_bottom;
   logic [ipdc_pkg::SUM_W-1:0] acc;
   logic [ipdc_pkg::PIX_W-1:0] planar_pix;
   logic [EdgeW-1:0]           dc2, dc3, corner_sum, row_sum, col_sum;
   logic [ipdc_pkg::PIX_W-1:0] dc_pix;

   always_comb begin
      n        = ipdc_pkg::CNT_W'(1) << calc_in.lg;
      w_left   = n - ipdc_pkg::CNT_W'(calc_in.pos_x) - ipdc_pkg::CNT_W'(1);
      w_right  = ipdc_pkg::CNT_W'(calc_in.pos_x) + ipdc_pkg::CNT_W'(1);
      w_top    = n - ipdc_pkg::CNT_W'(calc_in.pos_y) - ipdc_pkg::CNT_W'(1);
      w_bottom = ipdc_pkg::CNT_W'(calc_in.pos_y) + ipdc_pkg::CNT_W'(1);

      acc = ipdc_pkg::SUM_W'(w_left)   * ipdc_pkg::SUM_W'(calc_in.left_y)
          + ipdc_pkg::SUM_W'(w_right)  * ipdc_pkg::SUM_W'(calc_in.top_right)
          + ipdc_pkg::SUM_W'(w_top)    * ipdc_pkg::SUM_W'(calc_in.top_x)
          + ipdc_pkg::SUM_W'(w_bottom) * ipdc_pkg::SUM_W'(calc_in.bottom_left)
          + ipdc_pkg::SUM_W'(n);
      planar_pix = ipdc_pkg::PIX_W'(acc >> (calc_in.lg + ipdc_pkg::LG_W'(1)));

      // edge filter on row 0 and column 0
      dc2        = EdgeW'({calc_in.dc, 1'b0});
      dc3        = dc2 + EdgeW'(calc_in.dc);
      corner_sum = EdgeW'(calc_in.top_x) + EdgeW'(calc_in.left_y) + dc2 + EdgeW'(2);
      row_sum    = EdgeW'(calc_in.top_x) + dc3 + EdgeW'(2);
      col_sum    = EdgeW'(calc_in.left_y) + dc3 + EdgeW'(2);

      if (calc_in.pos_x == '0 && calc_in.pos_y == '0) begin
         dc_pix = ipdc_pkg::PIX_W'(corner_sum >> 2);
      end else if (calc_in.pos_y == '0) begin
         dc_pix = ipdc_pkg::PIX_W'(row_sum >> 2);
      end else if (calc_in.pos_x == '0) begin
         dc_pix = ipdc_pkg::PIX_W'(col_sum >> 2);
      end else begin
         dc_pix = calc_in.dc;
      end

      pix = (calc_in.mode == ipdc_pkg::MODE_DC) ? dc_pix : planar_pix;
   end

endmodule

FILE: hdl/intra_planar_dc_predictor.sv
// channel | direction | handshake             | payload
// req     | in        | req_tvalid/req_tready | tuser: command; tdata: index, value, mode, x, y
// rsp     | out       | rsp_tvalid/rsp_tready | tuser: position_error; tdata: pred_pixel
// csr     | in        | csr_wr_en             | csr_wr_data: block_log2_size
//
// a reference write is taken in idle and leaves it idle; a predict in range goes through calc if the cache is valid
// the cache (dc value, bottom-left, top-right) is rebuilt by a sweep on the first predict in range after
// any reference write within the line or any csr write, two memory reads per cycle
// the reference line sits in two mirrored single-read memories, so left and top come together
// reset is synchronous; the reference line is not cleared, only the cache and control state
// a result waiting in the output register does not block acceptance; the block stalls
// only when a new result is ready and the output register is still full
module intra_planar_dc_predictor #(
   parameter int MAX_BLOCK = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // ref_index[7:0], ref_value[15:8], pred_mode[16],
                                   // pos_x[21:17], pos_y[26:22], zero[31:27]
   input  logic        req_tuser,  // command[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // pred_pixel[7:0]
   output logic        rsp_tuser,  // position_error[0]
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data // block_log2_size[2:0]
);

   localparam int Depth   = 4 * MAX_BLOCK + 1;
   localparam int AddrW   = $clog2(Depth);
   localparam int LgFloor = $clog2(MAX_BLOCK + 1) - 1;
   localparam int LgCap   = (LgFloor > ipdc_pkg::LG_MAX) ? ipdc_pkg::LG_MAX : LgFloor;
   localparam logic [ipdc_pkg::LG_W-1:0] LgReset = (LgCap < 3) ? ipdc_pkg::LG_W'(LgCap)
                                                               : ipdc_pkg::LG_W'(3);

   // request fields
   logic [ipdc_pkg::IDX_W-1:0] f_index;
   logic [ipdc_pkg::PIX_W-1:0] f_value;
   logic                       f_mode;
   logic [ipdc_pkg::POS_W-1:0] f_x, f_y;

   assign f_index = req_tdata[7:0];
   assign f_value = req_tdata[15:8];
   assign f_mode  = req_tdata[16];
   assign f_x     = req_tdata[21:17];
   assign f_y     = req_tdata[26:22];

   // state and registers
   ipdc_pkg::state_type        state_ff, state_in;
   logic [ipdc_pkg::LG_W-1:0]  lg_ff, lg_in;
   logic                       cache_valid_ff;
   logic [ipdc_pkg::CNT_W-1:0] cnt_ff;
   logic [ipdc_pkg::SUM_W-1:0] sum_ff;
   logic [ipdc_pkg::PIX_W-1:0] bl_ff, tr_ff, dc_ff;
   logic [ipdc_pkg::POS_W-1:0] x_ff, y_ff;
   logic                       mode_ff;
   logic [ipdc_pkg::PIX_W-1:0] hold_pix_ff;
   logic                       hold_err_ff;
   logic                       rsp_valid_ff;
   logic [ipdc_pkg::PIX_W-1:0] rsp_pix_ff;
   logic                       rsp_err_ff;

   // reference line, mirrored so two entries can be read per cycle
   logic [ipdc_pkg::PIX_W-1:0] mem_a [Depth];
   logic [ipdc_pkg::PIX_W-1:0] mem_b [Depth];
   logic [ipdc_pkg::PIX_W-1:0] rd_a_ff, rd_b_ff;
   logic [AddrW-1:0]           rd_addr_a, rd_addr_b, wr_addr;
   logic                       wr_en;

   // control
   logic                       req_fire, slot_free, pos_err;
   logic                       rsp_load, hold_we;
   logic [ipdc_pkg::PIX_W-1:0] rsp_pix_in, hold_pix_in;
   logic                       rsp_err_in, hold_err_in;
   logic [ipdc_pkg::CNT_W-1:0] n_cnt;
   logic [AddrW-1:0]           n_addr;
   logic                       sweep_last;

   ipdc_pkg::calc_in_type      calc_in;
   logic [ipdc_pkg::PIX_W-1:0] calc_pix;

   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign n_cnt      = ipdc_pkg::CNT_W'(1) << lg_ff;
   assign n_addr     = AddrW'(1) << lg_ff;
   assign sweep_last = (cnt_ff == n_cnt + ipdc_pkg::CNT_W'(1));
   assign pos_err    = (ipdc_pkg::CNT_W'(f_x) >= n_cnt) || (ipdc_pkg::CNT_W'(f_y) >= n_cnt);

   // effective block size: clamp to the supported range
   always_comb begin
      if (csr_wr_data < ipdc_pkg::LG_W'(ipdc_pkg::LG_MIN)) begin
         lg_in = ipdc_pkg::LG_W'(ipdc_pkg::LG_MIN);
      end else if (csr_wr_data > ipdc_pkg::LG_W'(LgCap)) begin
         lg_in = ipdc_pkg::LG_W'(LgCap);
      end else begin
         lg_in = csr_wr_data;
      end
   end

   // write port: a write beyond the line is dropped
   assign wr_en   = req_fire && (req_tuser == ipdc_pkg::CMD_WRITE)
                    && (int'(f_index) < Depth);
   assign wr_addr = AddrW'(f_index);

   // read addresses
   always_comb begin
      // left[y] = 2n-1-y, top[x] = 2n+1+x
      rd_addr_a = (n_addr << 1) - AddrW'(y_ff) - AddrW'(1);
      rd_addr_b = (n_addr << 1) + AddrW'(x_ff) + AddrW'(1);
      case (state_ff)
         ipdc_pkg::ST_IDLE: begin
            rd_addr_a = (n_addr << 1) - AddrW'(f_y) - AddrW'(1);
            rd_addr_b = (n_addr << 1) + AddrW'(f_x) + AddrW'(1);
         end
         ipdc_pkg::ST_SWEEP: begin
            if (cnt_ff == n_cnt) begin
               // corners: bottom-left and top-right
               rd_addr_a = n_addr - AddrW'(1);
               rd_addr_b = (n_addr << 1) + n_addr + AddrW'(1);
            end else begin
               rd_addr_a = (n_addr << 1) - AddrW'(cnt_ff) - AddrW'(1);
               rd_addr_b = (n_addr << 1) + AddrW'(cnt_ff) + AddrW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_addr] <= f_value;
         mem_b[wr_addr] <= f_value;
      end
      rd_a_ff <= mem_a[rd_addr_a];
      rd_b_ff <= mem_b[rd_addr_b];
   end

   // pixel arithmetic
   always_comb begin
      calc_in.mode        = mode_ff;
      calc_in.pos_x       = x_ff;
      calc_in.pos_y       = y_ff;
      calc_in.lg          = lg_ff;
      calc_in.left_y      = rd_a_ff;
      calc_in.top_x       = rd_b_ff;
      calc_in.bottom_left = bl_ff;
      calc_in.top_right   = tr_ff;
      calc_in.dc          = dc_ff;
   end

   ipdc_pixel_calc u_calc (
      .calc_in (calc_in),
      .pix     (calc_pix)
   );

   // next state and outputs
   always_comb begin
      state_in    = state_ff;
      req_tready  = (state_ff == ipdc_pkg::ST_IDLE);
      rsp_load    = 1'b0;
      rsp_pix_in  = calc_pix;
      rsp_err_in  = 1'b0;
      hold_we     = 1'b0;
      hold_pix_in = calc_pix;
      hold_err_in = 1'b0;
      case (state_ff)
         ipdc_pkg::ST_IDLE: begin
            if (req_fire && req_tuser == ipdc_pkg::CMD_PREDICT) begin
               if (pos_err) begin
                  // out-of-block position: zero pixel with the error flag
                  rsp_pix_in  = '0;
                  rsp_err_in  = 1'b1;
                  hold_pix_in = '0;
                  hold_err_in = 1'b1;
                  if (slot_free) begin
                     rsp_load = 1'b1;
                  end else begin
                     hold_we  = 1'b1;
                     state_in = ipdc_pkg::ST_EMIT;
                  end
               end else if (cache_valid_ff) begin
                  state_in = ipdc_pkg::ST_CALC;
               end else begin
                  state_in = ipdc_pkg::ST_SWEEP;
               end
            end
         end
         ipdc_pkg::ST_SWEEP: begin
            if (sweep_last) begin
               state_in = ipdc_pkg::ST_REISSUE;
            end
         end
         ipdc_pkg::ST_REISSUE: begin
            state_in = ipdc_pkg::ST_CALC;
         end
         ipdc_pkg::ST_CALC: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ipdc_pkg::ST_IDLE;
            end else begin
               hold_we  = 1'b1;
               state_in = ipdc_pkg::ST_EMIT;
            end
         end
         ipdc_pkg::ST_EMIT: begin
            rsp_pix_in = hold_pix_ff;
            rsp_err_in = hold_err_ff;
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = ipdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ipdc_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ipdc_pkg::ST_IDLE;
         lg_ff          <= LgReset;
         cache_valid_ff <= 1'b0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            lg_ff <= lg_in;
         end
         // any change to the line or the size drops the cached block values
         if (csr_wr_en || wr_en) begin
            cache_valid_ff <= 1'b0;
         end else if (state_ff == ipdc_pkg::ST_SWEEP && sweep_last) begin
            cache_valid_ff <= 1'b1;
         end
         if (state_ff == ipdc_pkg::ST_SWEEP) begin
            cnt_ff <= cnt_ff + ipdc_pkg::CNT_W'(1);
         end else begin
            cnt_ff <= '0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff    <= f_x;
         y_ff    <= f_y;
         mode_ff <= f_mode;
      end
      if (state_ff == ipdc_pkg::ST_SWEEP) begin
         // read data arrives in the cycle after its address
         if (cnt_ff != '0 && cnt_ff <= n_cnt) begin
            sum_ff <= sum_ff + ipdc_pkg::SUM_W'(rd_a_ff) + ipdc_pkg::SUM_W'(rd_b_ff);
         end
         if (sweep_last) begin
            bl_ff <= rd_a_ff;
            tr_ff <= rd_b_ff;
            dc_ff <= ipdc_pkg::PIX_W'(sum_ff >> (lg_ff + ipdc_pkg::LG_W'(1)));
         end
      end else begin
         // seed with the rounding term n
         sum_ff <= ipdc_pkg::SUM_W'(n_cnt);
      end
      if (hold_we) begin
         hold_pix_ff <= hold_pix_in;
         hold_err_ff <= hold_err_in;
      end
      if (rsp_load) begin
         rsp_pix_ff <= rsp_pix_in;
         rsp_err_ff <= rsp_err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

FILE: hdl/ipdc_checker.sv
module ipdc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // an error result carries a zero pixel
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("position error with nonzero pixel");

   // a reference write never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result after a reference write");

endmodule

bind intra_planar_dc_predictor ipdc_checker u_ipdc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: test/tb_intra_planar_dc_predictor.sv
module tb_intra_planar_dc_predictor;

   localparam int MAX_BLOCK     = 32;
   localparam int LINE_DEPTH    = 4 * MAX_BLOCK + 1;
   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 11;
   // longest cache sweep (at n=32) plus the calc and emit stages, with margin
   localparam int SETTLE_CYCLES = 64;
   // long receiver hold-off used to fill the block and stall its input
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_ITEMS   = 85;
   localparam longint RUN_LIMIT = 5_000_000;

   // one request transaction, fields as carried on req_tdata / req_tuser
   typedef struct packed {
      logic                       command;
      logic [ipdc_pkg::IDX_W-1:0] index;
      logic [ipdc_pkg::PIX_W-1:0] value;
      logic                       mode;
      logic [ipdc_pkg::POS_W-1:0] px;
      logic [ipdc_pkg::POS_W-1:0] py;
   } ipred_req_type;

   localparam int REQ_BITS = $bits(ipred_req_type);

   // one response transaction
   typedef struct packed {
      logic                       err;
      logic [ipdc_pkg::PIX_W-1:0] pixel;
   } pixel_result_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wr_en   = 1'b0;
   logic [2:0]  csr_wr_data = '0;

   // local copy of the block state: reference line and size register
   logic [ipdc_pkg::PIX_W-1:0] ref_line [LINE_DEPTH];
   logic [ipdc_pkg::LG_W-1:0]  blk_log2 = 3'd3;

   // predicted pixels waiting for their response transaction, oldest first
   pixel_result_type pixel_due [$];

   int fail_count    = 0;
   int burst_left    = 0;
   bit offering      = 1'b0;
   bit gaps_enabled  = 1'b1;
   bit long_hold_req = 1'b0;

   // run statistics for the summary
   int n_writes  = 0;
   int n_planar  = 0;
   int n_dc      = 0;
   int n_pos_err = 0;
   int n_cfg     = 0;

   intra_planar_dc_predictor #(
      .MAX_BLOCK(MAX_BLOCK)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // effective log2 of n: register clamped to 2..5 and to the max block size
   function automatic int unsigned eff_log2();
      int unsigned lg;
      lg = 32'(blk_log2);
      if (lg < ipdc_pkg::LG_MIN) lg = ipdc_pkg::LG_MIN;
      if (lg > ipdc_pkg::LG_MAX) lg = ipdc_pkg::LG_MAX;
      while (lg > ipdc_pkg::LG_MIN && (1 << lg) > MAX_BLOCK) lg--;
      return lg;
   endfunction

   // expected pixel for a predict at (px, py) under the current line and size
   function automatic pixel_result_type predict_pixel(
      input logic                       mode,
      input logic [ipdc_pkg::POS_W-1:0] px,
      input logic [ipdc_pkg::POS_W-1:0] py);
      pixel_result_type res;
      int unsigned      lg, n, x, y, left_v, top_v, bl, tr, acc, dc, pix, i;
      lg  = eff_log2();
      n   = 1 << lg;
      x   = 32'(px);
      y   = 32'(py);
      res = '0;
      // position outside the block: pixel zero, error flag set
      if (x >= n || y >= n) begin
         res.err = 1'b1;
         return res;
      end
      left_v = 32'(ref_line[2*n - 1 - y]);
      top_v  = 32'(ref_line[2*n + 1 + x]);
      if (mode == ipdc_pkg::MODE_PLANAR) begin
         bl  = 32'(ref_line[n - 1]);
         tr  = 32'(ref_line[3*n + 1]);
         acc = (n - 1 - x) * left_v + (x + 1) * tr + (n - 1 - y) * top_v + (y + 1) * bl + n;
         pix = acc >> (lg + 1);
      end else begin
         // rounded mean of top row and left column
         acc = n;
         for (i = 0; i < n; i++) begin
            acc += 32'(ref_line[2*n + 1 + i]);
            acc += 32'(ref_line[2*n - 1 - i]);
         end
         dc = acc >> (lg + 1);
         // edge filter on row 0 and column 0, corner gets both neighbors
         if (x == 0 && y == 0)
            pix = (top_v + left_v + 2*dc + 2) >> 2;
         else if (y == 0)
            pix = (top_v + 3*dc + 2) >> 2;
         else if (x == 0)
            pix = (left_v + 3*dc + 2) >> 2;
         else
            pix = dc;
      end
      res.pixel = pix[ipdc_pkg::PIX_W-1:0];
      return res;
   endfunction

   function automatic ipred_req_type make_write(input int unsigned idx, input logic [7:0] val);
      ipred_req_type item;
      item         = REQ_BITS'($urandom);
      item.command = ipdc_pkg::CMD_WRITE;
      item.index   = idx[ipdc_pkg::IDX_W-1:0];
      item.value   = val;
      return item;
   endfunction

   function automatic ipred_req_type make_predict(input logic mode, input int unsigned x,
                                                  input int unsigned y);
      ipred_req_type item;
      item         = REQ_BITS'($urandom);
      item.command = ipdc_pkg::CMD_PREDICT;
      item.mode    = mode;
      item.px      = x[ipdc_pkg::POS_W-1:0];
      item.py      = y[ipdc_pkg::POS_W-1:0];
      return item;
   endfunction

   // random transaction: writes mostly land in the span the current block reads,
   // predicts mostly fall inside the block, the rest is free-range noise
   function automatic ipred_req_type random_request();
      ipred_req_type item;
      int unsigned   n, roll;
      n    = 1 << eff_log2();
      item = REQ_BITS'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
         item.command = ipdc_pkg::CMD_WRITE;
         if (roll < 2)
            item.index = ipdc_pkg::IDX_W'($urandom_range(LINE_DEPTH, 255));
         else if (roll < 8)
            item.index = ipdc_pkg::IDX_W'($urandom_range(0, LINE_DEPTH - 1));
         else
            item.index = ipdc_pkg::IDX_W'($urandom_range(n - 1, 3*n + 1));
         if ($urandom_range(0, 9) == 0)
            item.value = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      end else begin
         item.command = ipdc_pkg::CMD_PREDICT;
         if (roll < 88) begin
            item.px = ipdc_pkg::POS_W'($urandom_range(0, n - 1));
            item.py = ipdc_pkg::POS_W'($urandom_range(0, n - 1));
         end
      end
      return item;
   endfunction

   // offer one request transaction; bursts of random length with random gaps,
   // tvalid stays high on return so back-to-back transactions need no extra step
   task automatic issue_request(input ipred_req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gaps_enabled && gap > 0) begin
            if (offering) begin
               req_tvalid <= 1'b0;
               offering    = 1'b0;
            end
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= item.command;
      req_tdata  <= {5'b0, item.py, item.px, item.mode, item.value, item.index};
      offering    = 1'b1;
      do @(posedge clock); while (!req_tready);
      // transaction taken at this edge: advance the local state
      if (item.command == ipdc_pkg::CMD_WRITE) begin
         n_writes++;
         if (item.index < LINE_DEPTH) ref_line[item.index] = item.value;
      end else begin
         pixel_due.push_back(predict_pixel(item.mode, item.px, item.py));
         if (pixel_due[$].err) n_pos_err++;
         else if (item.mode == ipdc_pkg::MODE_PLANAR) n_planar++;
         else n_dc++;
      end
   endtask

   // stop offering and wait until every predicted pixel has come back
   task automatic wait_drain();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering    = 1'b0;
         @(posedge clock);
      end
      while (pixel_due.size() != 0) @(posedge clock);
   endtask

   // size register write, only with the block idle
   task automatic write_block_size(input logic [ipdc_pkg::LG_W-1:0] lg);
      wait_drain();
      // writes give no response, so let any cache sweep finish first
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lg;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      blk_log2   = lg;
      n_cfg++;
   endtask

   // whole reference line at full scale, so no later read hits an unwritten entry
   task automatic test_load_line();
      int unsigned i;
      for (i = 0; i < LINE_DEPTH; i++) issue_request(make_write(i, 8'hFF));
   endtask

   // saturated sums, block corners and edges, dropped writes, zero line, position errors
   task automatic test_directed_edges();
      int unsigned i;
      // reset block size, n = 8
      issue_request(make_predict(ipdc_pkg::MODE_PLANAR, 7, 7));
      issue_request(make_predict(ipdc_pkg::MODE_DC, 0, 0));
      // largest block, n = 32
      write_block_size(ipdc_pkg::LG_W'(ipdc_pkg::LG_MAX));
      issue_request(make_predict(ipdc_pkg::MODE_PLANAR, 31, 31));
      issue_request(make_predict(ipdc_pkg::MODE_PLANAR, 0, 31));
      issue_request(make_predict(ipdc_pkg::MODE_DC, 0, 0));
      issue_request(make_predict(ipdc_pkg::MODE_DC, 31, 0));
      issue_request(make_predict(ipdc_pkg::MODE_DC, 0, 31));
      issue_request(make_predict(ipdc_pkg::MODE_DC, 17, 9));
      // write beyond the line is dropped; last entry of the line goes to zero
      issue_request(make_write(255, 8'h00));
      issue_request(make_write(LINE_DEPTH - 1, 8'h00));
      // smallest block, n = 4, its whole span zeroed
      write_block_size(ipdc_pkg::LG_W'(ipdc_pkg::LG_MIN));
      for (i = 3; i <= 13; i++) issue_request(make_write(i, 8'h00));
      issue_request(make_predict(ipdc_pkg::MODE_DC, 0, 0));
      issue_request(make_predict(ipdc_pkg::MODE_PLANAR, 3, 3));
      issue_request(make_predict(ipdc_pkg::MODE_PLANAR, 4, 0));
      issue_request(make_predict(ipdc_pkg::MODE_DC, 0, 31));
      issue_request(make_predict(ipdc_pkg::MODE_DC, 31, 31));
   endtask

   // random traffic across register settings, out-of-range values included
   task automatic test_random_sizes();
      logic [ipdc_pkg::LG_W-1:0] sizes [10];
      int                        p, k, pause_at;
      sizes = '{3'd3, 3'd2, 3'd5, 3'd0, 3'd7, 3'd4, 3'd1, 3'd6, 3'd5, 3'd2};
      for (p = 0; p < 10; p++) begin
         write_block_size(sizes[p]);
         pause_at = $urandom_range(10, PHASE_ITEMS - 10);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            // sender pause mid-phase until all responses are in
            if (k == pause_at) wait_drain();
            issue_request(random_request());
         end
      end
   endtask

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      int k;
      write_block_size(ipdc_pkg::LG_W'(ipdc_pkg::LG_MAX));
      gaps_enabled  = 1'b0;
      long_hold_req = 1'b1;
      for (k = 0; k < 40; k++) issue_request(random_request());
      wait_drain();
      gaps_enabled = 1'b1;
   endtask

   // receiver: stall patterns that change after spans of random length,
   // plus the long hold-off on request, counted here in cycles
   initial begin
      int pattern, span, hold_count;
      bit ready_now;
      pattern = 0;
      span    = 0;
      forever begin
         if (long_hold_req) begin
            rsp_tready <= 1'b0;
            for (hold_count = 0; hold_count < LONG_HOLD; hold_count++) @(posedge clock);
            long_hold_req = 1'b0;
         end else begin
            if (span == 0) begin
               pattern = $urandom_range(0, 3);
               span    = $urandom_range(16, 96);
            end
            span--;
            case (pattern)
               0: begin
                  ready_now = 1'b1;
               end
               1: begin
                  ready_now = ($urandom_range(0, 1) == 1);
               end
               2: begin
                  ready_now = ($urandom_range(0, 7) != 0);
               end
               default: begin
                  ready_now = ($urandom_range(0, 9) < 2);
               end
            endcase
            rsp_tready <= ready_now;
            @(posedge clock);
         end
      end
   end

   // check each response transaction against the oldest predicted pixel
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_due.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected response, expected none, actual pixel %0d error %0b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = pixel_due.pop_front();
            if (rsp_tdata !== want.pixel) begin
               fail_count++;
               $display("%0t: pred_pixel mismatch, expected %0d actual %0d",
                        $time, want.pixel, rsp_tdata);
            end
            if (rsp_tuser !== want.err) begin
               fail_count++;
               $display("%0t: position_error mismatch, expected %0b actual %0b",
                        $time, want.err, rsp_tuser);
            end
         end
      end
   end

   // run limit
   initial begin
      #RUN_LIMIT;
      $display("FAIL intra_planar_dc_predictor");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_load_line();
      test_directed_edges();
      test_random_sizes();
      test_backpressure();
      wait_drain();
      // block latency margin: anything arriving now is an extra response
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pixel_due.size() != 0) begin
         fail_count++;
         $display("%0t: %0d predicted pixels never returned", $time, pixel_due.size());
      end
      $display("covered %0d reference writes, %0d planar and %0d dc pixels, %0d position errors",
               n_writes, n_planar, n_dc, n_pos_err);
      $display("over %0d size register writes, with receiver stalls and a long hold-off", n_cfg);
      if (fail_count == 0)
         $display("PASS intra_planar_dc_predictor");
      else
         $display("FAIL intra_planar_dc_predictor");
      $finish;
   end

endmodule
